@@ rtl/dws_pkg.sv @@
package dws_pkg;

  localparam int MUL_LATENCY = 3;
  localparam int MUL_STAGES  = MUL_LATENCY - 1;
  localparam int MUL_SLOTS   = 2;
  localparam int DIV_SLOTS   = 2;
  localparam int FP_SLOTS    = 4;
  localparam int TAG_BITS    = 16;
  localparam int REG_BITS    = 7;
  localparam int LAT_BITS    = 6;
  localparam int RESULT_CAP  = 8;
  localparam int CNT_BITS    = $clog2(RESULT_CAP);
  localparam int WAKE_N      = DIV_SLOTS + FP_SLOTS + MUL_SLOTS;
  localparam int WAKE_IDX_BITS = $clog2(WAKE_N);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [LAT_BITS-1:0] DIV_LAT_RESET = LAT_BITS'(32);

  localparam logic [4:0] FP_GRP_ADD = 5'b00000;
  localparam logic [4:0] FP_GRP_SUB = 5'b00001;
  localparam logic [4:0] FP_GRP_MUL = 5'b00010;
  localparam logic [4:0] FP_GRP_DIV = 5'b00011;
  localparam logic [6:0] FP_F7_SQRT = 7'h2C;
  localparam logic [6:0] FP_F7_CVT_W = 7'h60;
  localparam logic [6:0] FP_F7_CVT_S = 7'h68;
  localparam logic [LAT_BITS-1:0] FP_LAT_SHORT   = LAT_BITS'(3);
  localparam logic [LAT_BITS-1:0] FP_LAT_DEFAULT = LAT_BITS'(5);
  localparam logic [LAT_BITS-1:0] FP_LAT_LONG    = LAT_BITS'(10);

  typedef enum logic [1:0] {
    OP_ISSUE  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_TICK   = 2'd2,
    OP_BRANCH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    UNIT_OTHER = 3'd0,
    UNIT_MUL   = 3'd1,
    UNIT_DIV   = 3'd2,
    UNIT_FP    = 3'd3,
    UNIT_LOAD  = 3'd4,
    UNIT_STORE = 3'd5
  } unit_t;

  typedef enum logic [2:0] {
    SRC_LOAD = 3'd0,
    SRC_DIV  = 3'd1,
    SRC_FP   = 3'd2,
    SRC_MUL  = 3'd3,
    SRC_FAST = 3'd4
  } src_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WAKE,
    CMD_MUL,
    CMD_DIV,
    CMD_FP,
    CMD_TICK,
    CMD_BRANCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [REG_BITS-1:0]   rg;
    src_t                  src;
    logic [LAT_BITS-1:0]   count;
    logic [TAG_BITS-1:0]   tags;
    logic                  flush;
    logic                  kill;
    logic [TAG_BITS-1:0]   rmask;
  } cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [LAT_BITS-1:0]   count;
    logic [REG_BITS-1:0]   rg;
    logic [TAG_BITS-1:0]   tags;
  } slot_t;

  typedef struct packed {
    logic                  valid;
    logic [REG_BITS-1:0]   rg;
    logic [TAG_BITS-1:0]   tags;
  } mul_ent_t;

  function automatic logic [LAT_BITS-1:0] fp_latency(input logic [6:0] f7);
    logic [LAT_BITS-1:0] lat;
    unique case (f7[6:2])
      FP_GRP_ADD, FP_GRP_SUB: lat = FP_LAT_DEFAULT;
      FP_GRP_MUL:             lat = FP_LAT_SHORT;
      FP_GRP_DIV:             lat = FP_LAT_LONG;
      default: begin
        if (f7 == FP_F7_SQRT) lat = FP_LAT_LONG;
        else if (f7 == FP_F7_CVT_W || f7 == FP_F7_CVT_S) lat = FP_LAT_SHORT;
        else lat = FP_LAT_DEFAULT;
      end
    endcase
    return lat;
  endfunction

endpackage

@@ rtl/dws_if.sv @@
interface dws_in_if import dws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic                has_dest;
  logic [2:0]          unit_kind;
  logic [6:0]          func7;
  logic [REG_BITS-1:0] dest_reg;
  logic [TAG_BITS-1:0] branch_tags;
  logic [REG_BITS-1:0] load_reg;
  logic                full_flush;
  logic                mispredict;
  logic [TAG_BITS-1:0] kill_mask;
  logic [TAG_BITS-1:0] resolved_mask;

  modport source (
    output valid, op, has_dest, unit_kind, func7, dest_reg, branch_tags, load_reg,
           full_flush, mispredict, kill_mask, resolved_mask,
    input  ready
  );
  modport sink (
    input  valid, op, has_dest, unit_kind, func7, dest_reg, branch_tags, load_reg,
           full_flush, mispredict, kill_mask, resolved_mask,
    output ready
  );
endinterface

interface dws_out_if import dws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REG_BITS-1:0] wake_reg;
  logic [2:0]          src_code;
  logic                slot_full;
  logic                last;

  modport source (output valid, wake_reg, src_code, slot_full, last, input ready);
  modport sink (input valid, wake_reg, src_code, slot_full, last, output ready);
endinterface

interface dws_cfg_if import dws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LAT_BITS-1:0] divide_latency;

  modport source (output valid, divide_latency, input ready);
  modport sink (input valid, divide_latency, output ready);
endinterface

@@ rtl/dws_front.sv @@
module dws_front import dws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dws_in_if.sink      in_ch,
  dws_cfg_if.sink     cfg_ch,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_push_cmd
);

  logic [LAT_BITS-1:0] div_lat_r;
  logic [LAT_BITS-1:0] div_lat_nxt;
  logic [LAT_BITS-1:0] lat;
  cmd_t                cmd;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;

  always_comb begin
    div_lat_nxt = div_lat_r;
    if (cfg_ch.valid) div_lat_nxt = cfg_ch.divide_latency;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_lat_r <= DIV_LAT_RESET;
    end else begin
      div_lat_r <= div_lat_nxt;
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = CMD_NONE;
    cmd.src  = SRC_FAST;
    unique case (in_ch.unit_kind)
      UNIT_MUL: lat = LAT_BITS'(MUL_LATENCY);
      UNIT_DIV: lat = div_lat_r;
      UNIT_FP:  lat = fp_latency(in_ch.func7);
      default:  lat = LAT_BITS'(1);
    endcase
    unique case (in_ch.op)
      OP_ISSUE: begin
        cmd.rg    = in_ch.dest_reg;
        cmd.tags  = in_ch.branch_tags;
        cmd.count = lat - LAT_BITS'(1);
        if (!in_ch.has_dest) begin
          cmd.kind = CMD_NONE;
        end else if (lat <= LAT_BITS'(1)) begin
          if (in_ch.unit_kind == UNIT_LOAD || in_ch.unit_kind == UNIT_STORE) begin
            cmd.kind = CMD_NONE;
          end else begin
            cmd.kind = CMD_WAKE;
          end
        end else if (in_ch.unit_kind == UNIT_MUL) begin
          cmd.kind = CMD_MUL;
        end else if (in_ch.unit_kind == UNIT_DIV) begin
          cmd.kind = CMD_DIV;
        end else begin
          cmd.kind = CMD_FP;
        end
      end
      OP_LOAD: begin
        cmd.kind = CMD_WAKE;
        cmd.rg   = in_ch.load_reg;
        cmd.src  = SRC_LOAD;
      end
      OP_TICK: begin
        cmd.kind = CMD_TICK;
      end
      OP_BRANCH: begin
        cmd.kind  = CMD_BRANCH;
        cmd.flush = in_ch.full_flush;
        cmd.kill  = !in_ch.full_flush && in_ch.mispredict;
        cmd.tags  = in_ch.kill_mask;
        cmd.rmask = in_ch.resolved_mask;
      end
      default: cmd.kind = CMD_NONE;
    endcase
  end

  assign q_push     = in_ch.valid && !q_full && (cmd.kind != CMD_NONE);
  assign q_push_cmd = cmd;

endmodule

@@ rtl/dws_queue.sv @@
module dws_queue import dws_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + QPTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + QPTR_BITS'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + (QPTR_BITS+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (QPTR_BITS+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

@@ rtl/dws_back.sv @@
module dws_back import dws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  dws_out_if.source   out_ch
);

  slot_t    div_r [DIV_SLOTS];
  slot_t    div_nxt [DIV_SLOTS];
  slot_t    fp_r [FP_SLOTS];
  slot_t    fp_nxt [FP_SLOTS];
  mul_ent_t mul_r [MUL_STAGES][MUL_SLOTS];
  mul_ent_t mul_nxt [MUL_STAGES][MUL_SLOTS];

  logic [WAKE_N-1:0]   pend_r, pend_nxt;
  logic [REG_BITS-1:0] pend_reg_r [WAKE_N];
  logic [REG_BITS-1:0] pend_reg_nxt [WAKE_N];
  logic [CNT_BITS-1:0] emit_cnt_r, emit_cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [REG_BITS-1:0] out_wake_r, out_wake_nxt;
  src_t                out_src_r, out_src_nxt;
  logic                out_full_r, out_full_nxt;
  logic                out_last_r, out_last_nxt;

  logic                    can_out;
  logic                    hit;
  logic                    fin;
  logic [WAKE_IDX_BITS-1:0] idx;
  logic [WAKE_N-1:0]       rest;

  function automatic src_t wake_src(input logic [WAKE_IDX_BITS-1:0] i);
    return (i < WAKE_IDX_BITS'(DIV_SLOTS)) ? SRC_DIV :
           (i < WAKE_IDX_BITS'(DIV_SLOTS + FP_SLOTS)) ? SRC_FP : SRC_MUL;
  endfunction

  assign can_out          = !out_valid_r || out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.wake_reg  = out_wake_r;
  assign out_ch.src_code  = out_src_r;
  assign out_ch.slot_full = out_full_r;
  assign out_ch.last      = out_last_r;

  always_comb begin
    div_nxt       = div_r;
    fp_nxt        = fp_r;
    mul_nxt       = mul_r;
    pend_nxt      = pend_r;
    pend_reg_nxt  = pend_reg_r;
    emit_cnt_nxt  = emit_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_wake_nxt  = out_wake_r;
    out_src_nxt   = out_src_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    hit           = 1'b0;
    idx           = '0;
    rest          = '0;
    fin           = 1'b0;

    if (pend_r != '0) begin
      if (can_out) begin
        for (int i = 0; i < WAKE_N; i++) begin
          if (!hit && pend_r[i]) begin
            idx = WAKE_IDX_BITS'(i);
            hit = 1'b1;
          end
        end
        rest          = pend_r & ~(WAKE_N'(1) << idx);
        fin           = (rest == '0) || (emit_cnt_r == CNT_BITS'(RESULT_CAP - 1));
        out_valid_nxt = 1'b1;
        out_wake_nxt  = pend_reg_r[idx];
        out_src_nxt   = wake_src(idx);
        out_full_nxt  = 1'b0;
        out_last_nxt  = fin;
        pend_nxt      = fin ? '0 : rest;
        emit_cnt_nxt  = fin ? '0 : emit_cnt_r + CNT_BITS'(1);
      end
    end else if (q_valid && can_out) begin
      q_pop = 1'b1;
      unique case (q_cmd.kind)
        CMD_WAKE: begin
          out_valid_nxt = 1'b1;
          out_wake_nxt  = q_cmd.rg;
          out_src_nxt   = q_cmd.src;
          out_full_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
        end
        CMD_MUL: begin
          for (int i = 0; i < MUL_SLOTS; i++) begin
            if (!hit && !mul_r[0][i].valid) begin
              mul_nxt[0][i] = '{valid: 1'b1, rg: q_cmd.rg, tags: q_cmd.tags};
              hit = 1'b1;
            end
          end
          if (!hit) begin
            out_valid_nxt = 1'b1;
            out_wake_nxt  = '0;
            out_src_nxt   = SRC_MUL;
            out_full_nxt  = 1'b1;
            out_last_nxt  = 1'b1;
          end
        end
        CMD_DIV: begin
          for (int i = 0; i < DIV_SLOTS; i++) begin
            if (!hit && !div_r[i].valid) begin
              div_nxt[i] = '{valid: 1'b1, count: q_cmd.count, rg: q_cmd.rg, tags: q_cmd.tags};
              hit = 1'b1;
            end
          end
          if (!hit) begin
            out_valid_nxt = 1'b1;
            out_wake_nxt  = '0;
            out_src_nxt   = SRC_DIV;
            out_full_nxt  = 1'b1;
            out_last_nxt  = 1'b1;
          end
        end
        CMD_FP: begin
          for (int i = 0; i < FP_SLOTS; i++) begin
            if (!hit && !fp_r[i].valid) begin
              fp_nxt[i] = '{valid: 1'b1, count: q_cmd.count, rg: q_cmd.rg, tags: q_cmd.tags};
              hit = 1'b1;
            end
          end
          if (!hit) begin
            out_valid_nxt = 1'b1;
            out_wake_nxt  = '0;
            out_src_nxt   = SRC_FP;
            out_full_nxt  = 1'b1;
            out_last_nxt  = 1'b1;
          end
        end
        CMD_TICK: begin
          for (int i = 0; i < DIV_SLOTS; i++) begin
            pend_nxt[i]       = div_r[i].valid && (div_r[i].count == '0);
            pend_reg_nxt[i]   = div_r[i].rg;
            div_nxt[i].valid  = div_r[i].valid && (div_r[i].count != '0);
            div_nxt[i].count  = div_r[i].count - LAT_BITS'(1);
          end
          for (int i = 0; i < FP_SLOTS; i++) begin
            pend_nxt[DIV_SLOTS+i]     = fp_r[i].valid && (fp_r[i].count == '0);
            pend_reg_nxt[DIV_SLOTS+i] = fp_r[i].rg;
            fp_nxt[i].valid           = fp_r[i].valid && (fp_r[i].count != '0);
            fp_nxt[i].count           = fp_r[i].count - LAT_BITS'(1);
          end
          for (int i = 0; i < MUL_SLOTS; i++) begin
            pend_nxt[DIV_SLOTS+FP_SLOTS+i]     = mul_r[MUL_STAGES-1][i].valid;
            pend_reg_nxt[DIV_SLOTS+FP_SLOTS+i] = mul_r[MUL_STAGES-1][i].rg;
            mul_nxt[0][i].valid                = 1'b0;
          end
          for (int s = 1; s < MUL_STAGES; s++) begin
            mul_nxt[s] = mul_r[s-1];
          end
          emit_cnt_nxt = '0;
        end
        CMD_BRANCH: begin
          for (int i = 0; i < DIV_SLOTS; i++) begin
            if (q_cmd.flush || (q_cmd.kill && ((div_r[i].tags & q_cmd.tags) != '0))) begin
              div_nxt[i].valid = 1'b0;
            end else begin
              div_nxt[i].tags = div_r[i].tags & ~q_cmd.rmask;
            end
          end
          for (int i = 0; i < FP_SLOTS; i++) begin
            if (q_cmd.flush || (q_cmd.kill && ((fp_r[i].tags & q_cmd.tags) != '0))) begin
              fp_nxt[i].valid = 1'b0;
            end else begin
              fp_nxt[i].tags = fp_r[i].tags & ~q_cmd.rmask;
            end
          end
          for (int s = 0; s < MUL_STAGES; s++) begin
            for (int i = 0; i < MUL_SLOTS; i++) begin
              if (q_cmd.flush ||
                  (q_cmd.kill && ((mul_r[s][i].tags & q_cmd.tags) != '0))) begin
                mul_nxt[s][i].valid = 1'b0;
              end else begin
                mul_nxt[s][i].tags = mul_r[s][i].tags & ~q_cmd.rmask;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_SLOTS; i++) div_r[i].valid <= 1'b0;
      for (int i = 0; i < FP_SLOTS; i++) fp_r[i].valid <= 1'b0;
      for (int s = 0; s < MUL_STAGES; s++) begin
        for (int i = 0; i < MUL_SLOTS; i++) mul_r[s][i].valid <= 1'b0;
      end
      pend_r      <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      div_r       <= div_nxt;
      fp_r        <= fp_nxt;
      mul_r       <= mul_nxt;
      pend_r      <= pend_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_reg_r <= pend_reg_nxt;
    out_wake_r <= out_wake_nxt;
    out_src_r  <= out_src_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ rtl/delayed_wakeup_scheduler.sv @@
// Wakeup scheduler: turns issue, load-writeback and tick items into register wakes and
// applies branch items to the held slots. The front end accepts one item per cycle while
// the queue is not full into a two-entry command queue and drops items that cause no work.
// The back end takes one command per cycle when its output register is free and no tick
// wakes are pending; a tick ages the slots and then reports each wake it found (up to
// eight) in turn. Results leave through a single output register; the queue lets the input
// side keep moving while a result waits.
module delayed_wakeup_scheduler import dws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dws_in_if.sink    in_ch,
  dws_out_if.source out_ch,
  dws_cfg_if.sink   cfg_ch
);

  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  dws_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_cmd (q_push_cmd)
  );

  dws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop)
  );

  dws_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue read while empty");

  a_full_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.slot_full) |-> (out_ch.wake_reg == '0 && out_ch.last))
    else $error("slot_full result malformed");

  a_none_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_push_cmd.kind == CMD_NONE) |-> 1'b0)
    else $error("empty command queued");

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  import dws_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 85;
  localparam int MAX_GAP       = 5;

  localparam logic [2:0] UNIT_SPARE_LO = 3'd6;
  localparam logic [2:0] UNIT_SPARE_HI = 3'd7;

  typedef struct packed {
    op_t                 op;
    logic                has_dest;
    logic [2:0]          unit_kind;
    logic [6:0]          func7;
    logic [REG_BITS-1:0] dest_reg;
    logic [TAG_BITS-1:0] branch_tags;
    logic [REG_BITS-1:0] load_reg;
    logic                full_flush;
    logic                mispredict;
    logic [TAG_BITS-1:0] kill_mask;
    logic [TAG_BITS-1:0] resolved_mask;
  } sched_item_t;

  typedef struct packed {
    logic [REG_BITS-1:0] wake_reg;
    src_t                source;
    logic                slot_full;
    logic                last;
  } wake_t;

  typedef struct packed {
    sched_item_t item;
    logic        typed;
    logic        has_wake;
    wake_t       wake;
  } dir_row_t;

  typedef struct packed {
    logic                valid;
    logic [LAT_BITS-1:0] count;
    logic [REG_BITS-1:0] rg;
    logic [TAG_BITS-1:0] tags;
  } delay_slot_t;

  logic clk;
  logic rst_n;

  dws_in_if  in_ch();
  dws_out_if out_ch();
  dws_cfg_if cfg_ch();

  delayed_wakeup_scheduler i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  delay_slot_t         div_slot [DIV_SLOTS];
  delay_slot_t         fp_slot [FP_SLOTS];
  delay_slot_t         mul_stage [MUL_STAGES][MUL_SLOTS];
  logic [LAT_BITS-1:0] div_lat;
  wake_t               step_wakes[$];
  wake_t               pending_wakes[$];
  int                  fail_count = 0;
  int                  stall_cycles = 0;
  bit                  tx_idle_en = 1'b1;
  bit                  rx_idle_en = 1'b1;
  bit                  hold_req = 1'b0;

  function automatic int fp_cycles(logic [6:0] f7);
    case (f7[6:2])
      FP_GRP_ADD, FP_GRP_SUB: return int'(FP_LAT_DEFAULT);
      FP_GRP_MUL: return int'(FP_LAT_SHORT);
      FP_GRP_DIV: return int'(FP_LAT_LONG);
      default: begin
        if (f7 == FP_F7_SQRT) return int'(FP_LAT_LONG);
        else if (f7 == FP_F7_CVT_W || f7 == FP_F7_CVT_S) return int'(FP_LAT_SHORT);
        else return int'(FP_LAT_DEFAULT);
      end
    endcase
  endfunction

  function automatic void add_wake(logic [REG_BITS-1:0] rg, src_t src, logic full);
    wake_t w;
    w = '{wake_reg: rg, source: src, slot_full: full, last: 1'b0};
    if (step_wakes.size() < RESULT_CAP)
      step_wakes = {step_wakes, w};
  endfunction

  function automatic delay_slot_t branch_fixed(delay_slot_t e, bit kill,
                                               logic [TAG_BITS-1:0] kmask,
                                               logic [TAG_BITS-1:0] rmask);
    if (!e.valid) return e;
    if (kill && (e.tags & kmask) != '0) return '0;
    e.tags = e.tags & ~rmask;
    return e;
  endfunction

  function automatic delay_slot_t aged(delay_slot_t e);
    if (e.valid && e.count != '0) begin
      e.count = e.count - 1'b1;
      return e;
    end
    return '0;
  endfunction

  function automatic void clear_slots();
    for (int i = 0; i < DIV_SLOTS; i++) div_slot[i] = '0;
    for (int i = 0; i < FP_SLOTS; i++) fp_slot[i] = '0;
    for (int s = 0; s < MUL_STAGES; s++)
      for (int i = 0; i < MUL_SLOTS; i++) mul_stage[s][i] = '0;
  endfunction

  function automatic void predict_wakes(sched_item_t it);
    int    lat;
    bit    placed;
    bit    kill;
    step_wakes.delete();
    placed = 1'b0;
    case (it.op)
      OP_ISSUE: if (it.has_dest) begin
        lat = 1;
        if (it.unit_kind == UNIT_MUL) lat = MUL_LATENCY;
        else if (it.unit_kind == UNIT_DIV) lat = div_lat;
        else if (it.unit_kind == UNIT_FP) lat = fp_cycles(it.func7);
        if (lat <= 1) begin
          if (it.unit_kind != UNIT_LOAD && it.unit_kind != UNIT_STORE)
            add_wake(it.dest_reg, SRC_FAST, 1'b0);
        end else if (it.unit_kind == UNIT_MUL) begin
          for (int i = 0; i < MUL_SLOTS; i++)
            if (!placed && !mul_stage[0][i].valid) begin
              mul_stage[0][i] = '{valid: 1'b1, count: '0, rg: it.dest_reg,
                                  tags: it.branch_tags};
              placed = 1'b1;
            end
          if (!placed) add_wake('0, SRC_MUL, 1'b1);
        end else if (it.unit_kind == UNIT_DIV) begin
          for (int i = 0; i < DIV_SLOTS; i++)
            if (!placed && !div_slot[i].valid) begin
              div_slot[i] = '{valid: 1'b1, count: LAT_BITS'(lat - 1), rg: it.dest_reg,
                              tags: it.branch_tags};
              placed = 1'b1;
            end
          if (!placed) add_wake('0, SRC_DIV, 1'b1);
        end else begin
          for (int i = 0; i < FP_SLOTS; i++)
            if (!placed && !fp_slot[i].valid) begin
              fp_slot[i] = '{valid: 1'b1, count: LAT_BITS'(lat - 1), rg: it.dest_reg,
                             tags: it.branch_tags};
              placed = 1'b1;
            end
          if (!placed) add_wake('0, SRC_FP, 1'b1);
        end
      end
      OP_LOAD: add_wake(it.load_reg, SRC_LOAD, 1'b0);
      OP_TICK: begin
        for (int i = 0; i < DIV_SLOTS; i++)
          if (div_slot[i].valid && div_slot[i].count == '0)
            add_wake(div_slot[i].rg, SRC_DIV, 1'b0);
        for (int i = 0; i < FP_SLOTS; i++)
          if (fp_slot[i].valid && fp_slot[i].count == '0)
            add_wake(fp_slot[i].rg, SRC_FP, 1'b0);
        for (int i = 0; i < MUL_SLOTS; i++)
          if (mul_stage[MUL_STAGES-1][i].valid)
            add_wake(mul_stage[MUL_STAGES-1][i].rg, SRC_MUL, 1'b0);
        for (int i = 0; i < DIV_SLOTS; i++) div_slot[i] = aged(div_slot[i]);
        for (int i = 0; i < FP_SLOTS; i++) fp_slot[i] = aged(fp_slot[i]);
        for (int s = MUL_STAGES - 1; s >= 1; s--)
          for (int i = 0; i < MUL_SLOTS; i++) mul_stage[s][i] = mul_stage[s-1][i];
        for (int i = 0; i < MUL_SLOTS; i++) mul_stage[0][i] = '0;
      end
      default: begin
        kill = !it.full_flush && it.mispredict;
        if (it.full_flush) clear_slots();
        for (int i = 0; i < DIV_SLOTS; i++)
          div_slot[i] = branch_fixed(div_slot[i], kill, it.kill_mask, it.resolved_mask);
        for (int i = 0; i < FP_SLOTS; i++)
          fp_slot[i] = branch_fixed(fp_slot[i], kill, it.kill_mask, it.resolved_mask);
        for (int s = 0; s < MUL_STAGES; s++)
          for (int i = 0; i < MUL_SLOTS; i++)
            mul_stage[s][i] = branch_fixed(mul_stage[s][i], kill, it.kill_mask,
                                           it.resolved_mask);
      end
    endcase
    if (step_wakes.size() > 0) step_wakes[step_wakes.size() - 1].last = 1'b1;
  endfunction

  function automatic sched_item_t mk_issue(logic hd, logic [2:0] kind, logic [6:0] f7,
                                           logic [REG_BITS-1:0] rg,
                                           logic [TAG_BITS-1:0] tags);
    sched_item_t it;
    it             = '0;
    it.op          = OP_ISSUE;
    it.has_dest    = hd;
    it.unit_kind   = kind;
    it.func7       = f7;
    it.dest_reg    = rg;
    it.branch_tags = tags;
    return it;
  endfunction

  function automatic sched_item_t mk_load(logic [REG_BITS-1:0] rg);
    sched_item_t it;
    it          = '0;
    it.op       = OP_LOAD;
    it.load_reg = rg;
    return it;
  endfunction

  function automatic sched_item_t mk_tick();
    sched_item_t it;
    it    = '0;
    it.op = OP_TICK;
    return it;
  endfunction

  function automatic sched_item_t mk_branch(logic flush, logic misp,
                                            logic [TAG_BITS-1:0] kmask,
                                            logic [TAG_BITS-1:0] rmask);
    sched_item_t it;
    it               = '0;
    it.op            = OP_BRANCH;
    it.full_flush    = flush;
    it.mispredict    = misp;
    it.kill_mask     = kmask;
    it.resolved_mask = rmask;
    return it;
  endfunction

  function automatic dir_row_t row_chk(sched_item_t it);
    return '{item: it, typed: 1'b0, has_wake: 1'b0, wake: '0};
  endfunction

  function automatic dir_row_t row_none(sched_item_t it);
    return '{item: it, typed: 1'b1, has_wake: 1'b0, wake: '0};
  endfunction

  function automatic dir_row_t row_one(sched_item_t it, logic [REG_BITS-1:0] rg,
                                       src_t src, logic full);
    return '{item: it, typed: 1'b1, has_wake: 1'b1,
             wake: '{wake_reg: rg, source: src, slot_full: full, last: 1'b1}};
  endfunction

  function automatic logic [TAG_BITS-1:0] rand_tags();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return TAG_BITS'($urandom);
      4: return (TAG_BITS'(1) << $urandom_range(0, TAG_BITS - 1)) |
                (TAG_BITS'(1) << $urandom_range(0, TAG_BITS - 1));
      default: return TAG_BITS'(1) << $urandom_range(0, TAG_BITS - 1);
    endcase
  endfunction

  function automatic logic [6:0] rand_func7();
    case ($urandom_range(0, 5))
      0: return FP_F7_SQRT;
      1: return FP_F7_CVT_W;
      2: return FP_F7_CVT_S;
      default: return 7'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] rand_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return UNIT_MUL;
    if (r < 10) return UNIT_DIV;
    if (r < 16) return UNIT_FP;
    if (r == 16) return UNIT_OTHER;
    if (r == 17) return UNIT_LOAD;
    if (r == 18) return UNIT_STORE;
    return 3'($urandom_range(UNIT_SPARE_LO, UNIT_SPARE_HI));
  endfunction

  function automatic sched_item_t gen_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return mk_issue($urandom_range(0, 9) != 0, rand_kind(), rand_func7(),
                      REG_BITS'($urandom), rand_tags());
    if (r < 75) return mk_tick();
    if (r < 85) return mk_load(REG_BITS'($urandom));
    if (r < 87)
      return mk_branch(1'b1, 1'($urandom_range(0, 1)), rand_tags(), rand_tags());
    return mk_branch(1'b0, $urandom_range(0, 3) != 0, rand_tags(), rand_tags());
  endfunction

  task automatic drive_item(sched_item_t it);
    in_ch.op            <= it.op;
    in_ch.has_dest      <= it.has_dest;
    in_ch.unit_kind     <= it.unit_kind;
    in_ch.func7         <= it.func7;
    in_ch.dest_reg      <= it.dest_reg;
    in_ch.branch_tags   <= it.branch_tags;
    in_ch.load_reg      <= it.load_reg;
    in_ch.full_flush    <= it.full_flush;
    in_ch.mispredict    <= it.mispredict;
    in_ch.kill_mask     <= it.kill_mask;
    in_ch.resolved_mask <= it.resolved_mask;
  endtask

  task automatic send_item(sched_item_t it, bit typed, bit has_wake, wake_t wake);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    drive_item(it);
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_wakes(it);
    if (!typed) begin
      pending_wakes = {pending_wakes, step_wakes};
    end else if (has_wake) begin
      pending_wakes = {pending_wakes, wake};
    end
  endtask

  task automatic drain_wakes(int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_wakes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_div_latency(logic [LAT_BITS-1:0] v);
    @(negedge clk);
    cfg_ch.divide_latency <= v;
    cfg_ch.valid          <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    div_lat = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    wake_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_wakes.size() == 0) begin
        $error("unexpected wake: wake_reg %0d source %0d slot_full %0d last %0d",
               out_ch.wake_reg, out_ch.src_code, out_ch.slot_full, out_ch.last);
        fail_count++;
      end else begin
        exp_w = pending_wakes.pop_front();
        if (out_ch.wake_reg !== exp_w.wake_reg) begin
          $error("wake_reg: expected %0d, got %0d", exp_w.wake_reg, out_ch.wake_reg);
          fail_count++;
        end
        if (out_ch.src_code !== exp_w.source) begin
          $error("source: expected %0d, got %0d", exp_w.source, out_ch.src_code);
          fail_count++;
        end
        if (out_ch.slot_full !== exp_w.slot_full) begin
          $error("slot_full: expected %0d, got %0d", exp_w.slot_full, out_ch.slot_full);
          fail_count++;
        end
        if (out_ch.last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    dir_row_t rows[$];
    int       lat_plan [PHASES];
    rst_n = 1'b0;
    drive_item(mk_tick());
    in_ch.valid           <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.divide_latency <= DIV_LAT_RESET;
    clear_slots();
    div_lat = DIV_LAT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rows = {rows, row_none(mk_tick())};
    rows = {rows, row_one(mk_load('1), '1, SRC_LOAD, 1'b0)};
    rows = {rows, row_one(mk_load('0), '0, SRC_LOAD, 1'b0)};
    rows = {rows, row_one(mk_issue(1'b1, UNIT_OTHER, '1, '1, '1), '1, SRC_FAST, 1'b0)};
    rows = {rows, row_none(mk_issue(1'b0, UNIT_OTHER, '0, 7'd3, '0))};
    rows = {rows, row_none(mk_issue(1'b1, UNIT_LOAD, '0, 7'd4, '1))};
    rows = {rows, row_none(mk_issue(1'b1, UNIT_STORE, '1, 7'd5, '0))};
    rows = {rows, row_one(mk_issue(1'b1, UNIT_SPARE_LO, '0, 7'd6, '0), 7'd6,
                          SRC_FAST, 1'b0)};
    rows = {rows, row_one(mk_issue(1'b1, UNIT_SPARE_HI, '1, '0, '1), '0,
                          SRC_FAST, 1'b0)};
    rows = {rows, row_chk(mk_issue(1'b1, UNIT_MUL, '0, 7'd10, '1))};
    rows = {rows, row_chk(mk_issue(1'b1, UNIT_MUL, '0, 7'd11, 16'h0001))};
    rows = {rows, row_one(mk_issue(1'b1, UNIT_MUL, '0, 7'd12, '0), '0, SRC_MUL, 1'b1)};
    rows = {rows, row_chk(mk_issue(1'b1, UNIT_DIV, '0, 7'd20, 16'h8000))};
    rows = {rows, row_chk(mk_issue(1'b1, UNIT_DIV, '0, 7'd21, 16'h0100))};
    rows = {rows, row_one(mk_issue(1'b1, UNIT_DIV, '0, 7'd22, '0), '0, SRC_DIV, 1'b1)};
    rows = {rows, row_chk(mk_issue(1'b1, UNIT_FP, {FP_GRP_ADD, 2'b00}, 7'd30, '0))};
    rows = {rows, row_chk(mk_issue(1'b1, UNIT_FP, {FP_GRP_MUL, 2'b00}, 7'd31, '1))};
    rows = {rows, row_chk(mk_issue(1'b1, UNIT_FP, {FP_GRP_DIV, 2'b11}, 7'd32, '0))};
    rows = {rows, row_chk(mk_issue(1'b1, UNIT_FP, FP_F7_SQRT, 7'd33, 16'h8000))};
    rows = {rows, row_one(mk_issue(1'b1, UNIT_FP, FP_F7_CVT_W, 7'd34, '0), '0,
                          SRC_FP, 1'b1)};
    rows = {rows, row_chk(mk_tick())};
    rows = {rows, row_chk(mk_tick())};
    rows = {rows, row_none(mk_branch(1'b0, 1'b1, 16'h8000, 16'h0001))};
    rows = {rows, row_none(mk_branch(1'b1, 1'b1, '0, '1))};
    rows = {rows, row_chk(mk_issue(1'b1, UNIT_FP, FP_F7_CVT_S, '1, '1))};
    foreach (rows[k]) send_item(rows[k].item, rows[k].typed, rows[k].has_wake, rows[k].wake);
    drain_wakes(SETTLE_CYCLES);

    lat_plan = '{2, 63, 1, 0, 32, 2};
    lat_plan[4] = $urandom_range(2, 63);
    lat_plan[5] = $urandom_range(2, 8);
    for (int p = 0; p < PHASES; p++) begin
      write_div_latency(LAT_BITS'(lat_plan[p]));
      tx_idle_en = (p != 2 && p != 3);
      rx_idle_en = (p != 1 && p != 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 40) hold_req = 1'b1;
        if (p == 2 && k == 40) drain_wakes(0);
        send_item(gen_item(), 1'b0, 1'b0, '0);
      end
      drain_wakes(SETTLE_CYCLES);
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
